/* rtl/core/rfg_pkg.sv */
// Package for the ranging frame gatherer: frame layout constants, default sizes,
// transfer payload types, status codes, controller states and control structs.
// No dependencies.
package rfg_pkg;

    // Default store sizes
    localparam int DEF_NUM_TAGS    = 200;
    localparam int DEF_NUM_SLOTS   = 8;
    localparam int DEF_NUM_ANCHORS = 4;

    // Field moduli
    localparam logic [7:0] ANCHOR_MOD = 8'd250;
    localparam logic [8:0] TAG_MOD    = 9'd200;
    localparam logic [8:0] TAG_MOD2   = 9'd400;

    // Byte positions within a frame
    localparam logic [7:0] POS_ANCHOR     = 8'd23;
    localparam logic [7:0] POS_TAG_FIRST  = 8'd24;
    localparam logic [7:0] POS_TAG_LAST   = 8'd27;
    localparam logic [7:0] POS_DIST_FIRST = 8'd28;
    localparam logic [7:0] POS_DIST_LAST  = 8'd31;
    localparam logic [7:0] POS_BATCH      = 8'd33;
    localparam logic [7:0] MIN_LENGTH     = 8'd34;
    localparam logic [7:0] POS_SAT        = 8'd255;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_BAD_CHECKSUM = 2'd0,
        STAT_DROPPED      = 2'd1,
        STAT_STORED       = 2'd2,
        STAT_COMPLETE     = 2'd3
    } rfg_status_t;

    // Input transfer payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } rfg_in_t;

    // Result transfer payload
    typedef struct packed {
        rfg_status_t status;
        logic [7:0]  tag_number;
        logic [7:0]  batch_number;
        logic [31:0] distance_one;
        logic [31:0] distance_two;
        logic [31:0] distance_three;
        logic [31:0] distance_four;
    } rfg_out_t;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_COLLECT,
        S_EVAL,
        S_READ,
        S_UPDATE
    } rfg_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic byte_take;
        logic frame_clear;
        logic clr_step;
        logic row_load;
        logic store;
        logic out_load_drop;
    } rfg_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clr_done;
        logic frame_bad;
        logic out_free;
    } rfg_sts_t;

endpackage

/* rtl/core/rfg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rfg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/rfg_ctrl.sv */
// Controller for the ranging frame gatherer: clearing pass, byte intake,
// end-of-frame decision and slot update sequencing.
// Depends on rfg_pkg.
module rfg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    input  logic              frame_end,
    output logic              byte_stall,
    input  rfg_pkg::rfg_sts_t sts,
    output rfg_pkg::rfg_cmd_t cmd
);
    import rfg_pkg::*;

    rfg_state_t state_reg;
    rfg_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        byte_stall = 1'b1;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = S_COLLECT;
                end
            end
            S_COLLECT:
            begin
                byte_stall    = 1'b0;
                cmd.byte_take = byte_valid;
                if (byte_valid && frame_end)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                // wait for the result register to drain
                if (sts.out_free)
                begin
                    if (sts.frame_bad)
                    begin
                        cmd.out_load_drop = 1'b1;
                        cmd.frame_clear   = 1'b1;
                        state_next        = S_COLLECT;
                    end
                    else
                    begin
                        cmd.row_load = 1'b1;
                        state_next   = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.store       = 1'b1;
                cmd.frame_clear = 1'b1;
                state_next      = S_COLLECT;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

/* rtl/core/rfg_datapath.sv */
// Datapath for the ranging frame gatherer: per-frame capture registers, row
// index, presence and distance stores, and the result register.
// Depends on rfg_pkg and rfg_ram.
module rfg_datapath #(
    parameter int NUM_TAGS    = rfg_pkg::DEF_NUM_TAGS,
    parameter int NUM_SLOTS   = rfg_pkg::DEF_NUM_SLOTS,
    parameter int NUM_ANCHORS = rfg_pkg::DEF_NUM_ANCHORS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rfg_pkg::rfg_in_t  byte_item,
    input  rfg_pkg::rfg_cmd_t cmd,
    output rfg_pkg::rfg_sts_t sts,
    output rfg_pkg::rfg_out_t result,
    output logic              result_valid,
    input  logic              result_stall
);
    import rfg_pkg::*;

    localparam int ROWS      = NUM_TAGS * NUM_SLOTS;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int TAG_IDX_W = (NUM_TAGS > 1) ? $clog2(NUM_TAGS) : 1;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int ANCH_W    = $clog2(NUM_ANCHORS);

    // Per-frame capture registers
    logic [7:0]  pos_reg;
    logic [7:0]  parity_reg;
    logic [7:0]  anchor_reg;
    logic [7:0]  tag_reg;
    logic [31:0] dist_reg;
    logic [7:0]  batch_reg;

    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] clr_cnt_reg;
    rfg_out_t         out_reg;
    logic             out_valid_reg;

    logic [7:0]  in_byte;
    logic [8:0]  tag_add;
    logic [7:0]  tag_fold;
    logic [7:0]  anchor_fold;

    logic             parity_bad;
    logic             short_frame;
    logic             anchor_bad;
    logic [ANCH_W-1:0] anchor_idx;
    logic [ROW_W-1:0] row_next;

    logic [TAG_IDX_W-1:0] tag_idx_tab [256];
    logic [SLOT_W-1:0]    slot_tab [256];

    logic                   pres_we;
    logic [ROW_W-1:0]       pres_waddr;
    logic [NUM_ANCHORS-1:0] pres_wdata;
    logic [NUM_ANCHORS-1:0] pres_rd;
    logic [NUM_ANCHORS-1:0] pres_new;
    logic                   set_full;
    logic [31:0]            dist_rd [NUM_ANCHORS];
    logic [31:0]            dist_sel [4];

    // Constant lookup tables for tag row and slot (value mod size)
    for (genvar i = 0; i < 256; i++)
    begin : g_tab
        assign tag_idx_tab[i] = TAG_IDX_W'(i % NUM_TAGS);
        assign slot_tab[i]    = SLOT_W'(i % NUM_SLOTS);
    end

    // Byte folding: tag kept mod 200 as bytes arrive, anchor mod 250
    assign in_byte     = byte_item.data_byte;
    assign tag_add     = {1'b0, tag_reg} + {1'b0, in_byte};
    assign tag_fold    = (tag_add >= TAG_MOD2) ? 8'(tag_add - TAG_MOD2) :
                         (tag_add >= TAG_MOD)  ? 8'(tag_add - TAG_MOD)  : tag_add[7:0];
    assign anchor_fold = (in_byte >= ANCHOR_MOD) ? (in_byte - ANCHOR_MOD) : in_byte;

    // Frame capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            parity_reg <= '0;
            anchor_reg <= '0;
            tag_reg    <= '0;
            dist_reg   <= '0;
            batch_reg  <= '0;
        end
        else if (cmd.frame_clear)
        begin
            pos_reg    <= '0;
            parity_reg <= '0;
            anchor_reg <= '0;
            tag_reg    <= '0;
            dist_reg   <= '0;
            batch_reg  <= '0;
        end
        else if (cmd.byte_take)
        begin
            parity_reg <= parity_reg ^ in_byte;
            if (pos_reg == POS_ANCHOR)
            begin
                anchor_reg <= anchor_fold;
            end
            if (pos_reg >= POS_TAG_FIRST && pos_reg <= POS_TAG_LAST)
            begin
                tag_reg <= tag_fold;
            end
            if (pos_reg >= POS_DIST_FIRST && pos_reg <= POS_DIST_LAST)
            begin
                dist_reg <= {dist_reg[23:0], in_byte};
            end
            if (pos_reg == POS_BATCH)
            begin
                batch_reg <= in_byte;
            end
            if (pos_reg != POS_SAT)
            begin
                pos_reg <= pos_reg + 8'd1;
            end
        end
    end

    // End-of-frame checks (position already counts the last byte)
    assign parity_bad  = (parity_reg != 8'd0);
    assign short_frame = (pos_reg < MIN_LENGTH);
    assign anchor_bad  = (anchor_reg == 8'd0) || (anchor_reg > 8'(NUM_ANCHORS));
    assign anchor_idx  = ANCH_W'(anchor_reg - 8'd1);

    assign row_next = ROW_W'(32'(tag_idx_tab[tag_reg]) * 32'(NUM_SLOTS)
                             + 32'(slot_tab[batch_reg]));

    // Row index register
    always_ff @(posedge clk)
    begin
        if (cmd.row_load)
        begin
            row_reg <= row_next;
        end
    end

    // Clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + ROW_W'(1);
        end
    end

    // Presence store
    assign pres_new   = pres_rd | (NUM_ANCHORS'(1) << anchor_idx);
    assign set_full   = &pres_new;
    assign pres_we    = cmd.clr_step || cmd.store;
    assign pres_waddr = cmd.clr_step ? clr_cnt_reg : row_reg;
    assign pres_wdata = (cmd.clr_step || set_full) ? '0 : pres_new;

    rfg_ram #(
        .WIDTH (NUM_ANCHORS),
        .DEPTH (ROWS)
    ) u_pres_ram (
        .clk   (clk),
        .we    (pres_we),
        .waddr (pres_waddr),
        .wdata (pres_wdata),
        .raddr (row_reg),
        .rdata (pres_rd)
    );

    // One distance store per anchor
    for (genvar a = 0; a < NUM_ANCHORS; a++)
    begin : g_dist
        rfg_ram #(
            .WIDTH (32),
            .DEPTH (ROWS)
        ) u_dist_ram (
            .clk   (clk),
            .we    (cmd.store && (anchor_idx == ANCH_W'(a))),
            .waddr (row_reg),
            .wdata (dist_reg),
            .raddr (row_reg),
            .rdata (dist_rd[a])
        );
    end

    // Distance set: the new distance bypasses its store
    for (genvar k = 0; k < 4; k++)
    begin : g_sel
        if (k < NUM_ANCHORS)
        begin : g_used
            assign dist_sel[k] = (anchor_idx == ANCH_W'(k)) ? dist_reg : dist_rd[k];
        end
        else
        begin : g_unused
            assign dist_sel[k] = '0;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load_drop)
        begin
            out_reg.status         <= parity_bad ? STAT_BAD_CHECKSUM : STAT_DROPPED;
            out_reg.tag_number     <= '0;
            out_reg.batch_number   <= '0;
            out_reg.distance_one   <= '0;
            out_reg.distance_two   <= '0;
            out_reg.distance_three <= '0;
            out_reg.distance_four  <= '0;
        end
        else if (cmd.store)
        begin
            out_reg.status         <= set_full ? STAT_COMPLETE : STAT_STORED;
            out_reg.tag_number     <= tag_reg;
            out_reg.batch_number   <= batch_reg;
            out_reg.distance_one   <= set_full ? dist_sel[0] : '0;
            out_reg.distance_two   <= set_full ? dist_sel[1] : '0;
            out_reg.distance_three <= set_full ? dist_sel[2] : '0;
            out_reg.distance_four  <= set_full ? dist_sel[3] : '0;
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load_drop || cmd.store)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    // Status to controller
    assign sts.clr_done  = (clr_cnt_reg == ROW_W'(ROWS - 1));
    assign sts.frame_bad = parity_bad || short_frame || anchor_bad;
    assign sts.out_free  = !out_valid_reg || !result_stall;

endmodule

/* rtl/core/ranging_frame_gatherer.sv */
// Top level of the ranging frame gatherer: controller, datapath and assertions.
// Depends on rfg_pkg, rfg_ctrl, rfg_datapath (and rfg_ram below it).
//
// Frames arrive one byte per transfer and are taken at one byte per cycle
// while collecting. On the byte that ends a frame, input stalls while the
// frame is judged: a frame with bad checksum, fewer than 34 bytes or an anchor
// outside 1..NUM_ANCHORS yields status 0 or 1; a good frame passes through
// row index, read of the presence and distance stores and slot update, and
// yields status 2, or 3 with the full distance set, after which the slot is
// emptied. The stores have registered reads, so that read-then-update pass
// sets the per-frame overhead. The judging step also waits while the result
// register still holds an untaken result.
// After reset a clearing pass over all NUM_TAGS*NUM_SLOTS rows (1600 at the
// defaults) empties the presence store; no byte is taken until it is done.
module ranging_frame_gatherer #(
    parameter int NUM_TAGS    = rfg_pkg::DEF_NUM_TAGS,
    parameter int NUM_SLOTS   = rfg_pkg::DEF_NUM_SLOTS,
    parameter int NUM_ANCHORS = rfg_pkg::DEF_NUM_ANCHORS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_valid,
    output logic             byte_stall,
    input  rfg_pkg::rfg_in_t byte_item,
    output logic             result_valid,
    input  logic             result_stall,
    output rfg_pkg::rfg_out_t result
);
    import rfg_pkg::*;

    rfg_cmd_t cmd;
    rfg_sts_t sts;

    // Sequencer
    rfg_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .frame_end  (byte_item.frame_end),
        .byte_stall (byte_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    // Capture, stores and result register
    rfg_datapath #(
        .NUM_TAGS    (NUM_TAGS),
        .NUM_SLOTS   (NUM_SLOTS),
        .NUM_ANCHORS (NUM_ANCHORS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_item    (byte_item),
        .cmd          (cmd),
        .sts          (sts),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

`ifndef NO_ASSERTIONS
    // No byte is taken during the clearing pass
    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_step |-> byte_stall)
        else $error("byte input open during clearing pass");

    // A result is only loaded when the result register is free
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.store || cmd.out_load_drop) |-> (!result_valid || !result_stall))
        else $error("result register overwritten before transfer");

    // A slot update presents a stored or complete result next cycle
    a_store_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |=> (result_valid &&
                       (result.status == STAT_STORED || result.status == STAT_COMPLETE)))
        else $error("slot update did not yield a stored result");

    // A dropped frame presents a checksum or drop result next cycle
    a_drop_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load_drop |=> (result_valid &&
                       (result.status == STAT_BAD_CHECKSUM || result.status == STAT_DROPPED)))
        else $error("dropped frame did not yield a drop result");
`endif

endmodule
